// File: rtl/ier_pkg.sv
// Package with types, constants and table functions for the ice effective radius block.
`timescale 1ns / 1ps
package ier_pkg;

	localparam int unsigned TEMP_W = 17;
	localparam int unsigned ICE_W = 40;
	localparam int unsigned PRES_W = 21;
	localparam int unsigned VAP_W = 32;
	localparam int unsigned RAD_W = 16;
	localparam int unsigned CFG_W = 20;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned DEF_LOG_TABLE_DEPTH = 256;

	// Width of a log2 value in unsigned Q.16.
	localparam int unsigned LOG_W = 24;
	// Table entry widths.
	localparam int unsigned LGT_W = 17;
	localparam int unsigned EXT_W = 32;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FREEZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VFAC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ICE = 2'd3;

	localparam logic [16:0] RST_FREEZE = 17'd69929;
	localparam logic [16:0] RST_GAS = 17'd73485;
	localparam logic [15:0] RST_VFAC = 16'd39826;
	localparam logic [19:0] RST_MIN_ICE = 20'd10995;

	localparam logic [RAD_W-1:0] RAD_FLOOR = 16'd1280;
	localparam logic [RAD_W-1:0] RAD_MAX = 16'hFFFF;

	// Result kind decided at the front of the pipe.
	typedef struct packed {
		logic below;
		logic floor_only;
	} ier_flags_t;

	function automatic logic signed [19:0] band_lcoef(input logic [1:0] b);
		logic signed [19:0] r;
		unique case (b)
			2'd0: r = 20'sd457298;
			2'd1: r = 20'sd462996;
			2'd2: r = 20'sd464311;
			default: r = 20'sd462491;
		endcase
		return r;
	endfunction

	function automatic logic [12:0] band_expo(input logic [1:0] b);
		logic [12:0] r;
		unique case (b)
			2'd0: r = 13'd7143;
			2'd1: r = 13'd5243;
			2'd2: r = 13'd3604;
			default: r = 13'd2032;
		endcase
		return r;
	endfunction

	// Integer square root used to build the exp2 roots at elaboration.
	function automatic longint unsigned isqrt64(input longint unsigned xin);
		longint unsigned x, r, bt;
		x = xin;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// log2(1 + i/depth) in Q.16 by successive squaring; depth is a power of two.
	function automatic logic [LGT_W-1:0] lg_entry(input int unsigned i,
			input int unsigned depth);
		longint unsigned y, acc;
		y = (64'd1 << 30) + ((longint'(i) << 30) >> $clog2(depth));
		acc = 0;
		for (int k = 0; k < 20; k++) begin
			y = (y * y) >> 30;
			acc = acc << 1;
			if (y >= (64'd2 << 30)) begin
				acc = acc | 64'd1;
				y = y >> 1;
			end
		end
		return LGT_W'((acc + 64'd8) >> 4);
	endfunction

	// 2^(i/depth) in Q30; depth is a power of two.
	function automatic logic [EXT_W-1:0] ex_entry(input int unsigned i,
			input int unsigned depth);
		longint unsigned root [21];
		longint unsigned g, r;
		root[0] = 64'd1 << 31;
		for (int k = 1; k <= 20; k++) root[k] = isqrt64(root[k-1] << 30);
		g = (longint'(i) << 20) >> $clog2(depth);
		if (g >= (64'd1 << 20)) begin
			r = 64'd1 << 31;
		end else begin
			r = 64'd1 << 30;
			for (int k = 1; k <= 20; k++)
				if (((g >> (20 - k)) & 64'd1) != 0) r = (r * root[k]) >> 30;
		end
		return EXT_W'(r);
	endfunction

endpackage

// File: rtl/ier_log2.sv
// Two-stage log2 unit: leading-one search and table lookup, then interpolation.
`timescale 1ns / 1ps
module ier_log2 #(
	parameter int unsigned IN_W = 49,
	parameter int unsigned DEPTH = 256
) (
	input  logic clk,
	input  logic en1,
	input  logic en2,
	input  logic [IN_W-1:0] x,
	output logic [ier_pkg::LOG_W-1:0] lg
);
	import ier_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned MSB_W = $clog2(IN_W);

	logic [MSB_W-1:0] msb;
	logic [31:0] frac;
	logic [63:0] xs;
	logic [IDX_W+31:0] pos;
	logic [IDX_W-1:0] idx;
	logic [MSB_W-1:0] msb_s1;
	logic [LGT_W-1:0] lo_s1, hi_s1;
	logic [15:0] rem_s1;
	logic [LGT_W-1:0] tab [DEPTH+1];

	// Constant table built at elaboration.
	always_comb begin
		for (int i = 0; i <= DEPTH; i++) tab[i] = lg_entry(i, DEPTH);
	end

	// Leading one and the 32 bits under it.
	always_comb begin
		msb = '0;
		for (int b = 0; b < IN_W; b++) if (x[b]) msb = MSB_W'(b);
		xs = 64'(x) << (7'd63 - 7'(msb));
		frac = xs[62:31];
		pos = (IDX_W+32)'(frac) * (IDX_W+32)'(DEPTH);
		idx = pos[IDX_W+31:32];
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			msb_s1 <= msb;
			lo_s1 <= tab[idx];
			hi_s1 <= tab[32'(idx) + 1];
			rem_s1 <= pos[31:16];
		end
	end

	// Interpolate between neighbors, truncating.
	logic [LGT_W+15:0] prod;
	assign prod = (LGT_W+16)'(hi_s1 - lo_s1) * (LGT_W+16)'(rem_s1);
	always_ff @(posedge clk) begin
		if (en2) lg <= (LOG_W'(msb_s1) << 16) + LOG_W'(lo_s1) + LOG_W'(prod[LGT_W+15:16]);
	end
endmodule

// File: rtl/ier_exp2.sv
// Two-stage exp2 unit with saturation and the lower floor.
`timescale 1ns / 1ps
module ier_exp2 #(
	parameter int unsigned DEPTH = 256
) (
	input  logic clk,
	input  logic en1,
	input  logic en2,
	input  logic signed [ier_pkg::LOG_W+1:0] x,
	output logic [ier_pkg::RAD_W-1:0] rad
);
	import ier_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);

	logic [EXT_W-1:0] tab [DEPTH+1];
	logic signed [LOG_W-14:0] n;
	logic [15:0] f;
	logic [IDX_W+15:0] pos;
	logic [IDX_W-1:0] idx;
	logic sat_s1, zero_s1;
	logic [4:0] sh_s1;
	logic [EXT_W-1:0] lo_s1, hi_s1;
	logic [15:0] rem_s1;

	always_comb begin
		for (int i = 0; i <= DEPTH; i++) tab[i] = ex_entry(i, DEPTH);
	end

	// Integer part by arithmetic shift is the floor.
	always_comb begin
		n = (LOG_W-13)'(x >>> 16);
		f = x[15:0];
		pos = (IDX_W+16)'(f) * (IDX_W+16)'(DEPTH);
		idx = pos[IDX_W+15:16];
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sat_s1 <= n >= 16;
			zero_s1 <= n < 0;
			sh_s1 <= 5'(30 - n[4:0]);
			lo_s1 <= tab[idx];
			hi_s1 <= tab[32'(idx) + 1];
			rem_s1 <= pos[15:0];
		end
	end

	logic [EXT_W+15:0] prod;
	logic [EXT_W-1:0] mant;
	logic [RAD_W-1:0] r;
	assign prod = (EXT_W+16)'(hi_s1 - lo_s1) * (EXT_W+16)'(rem_s1);
	always_comb begin
		mant = (lo_s1 + prod[EXT_W+15:16]) >> sh_s1;
		priority if (sat_s1) r = RAD_MAX;
		else if (zero_s1) r = '0;
		else if (mant > EXT_W'(RAD_MAX)) r = RAD_MAX;
		else r = mant[RAD_W-1:0];
		if (r < RAD_FLOOR) r = RAD_FLOOR;
	end

	always_ff @(posedge clk) begin
		if (en2) rad <= r;
	end
endmodule

// File: rtl/ice_effective_radius.sv
// Top level of the ice effective radius pipeline.
// Throughput: one item per cycle; the stall input freezes every stage together.
// Configuration registers return to their defaults on arst_n; valid bits clear.
// The pipeline depth is set by the log2 unit, the exponent multiply and the exp2 unit.
`timescale 1ns / 1ps
module ice_effective_radius #(
	parameter int unsigned LOG_TABLE_DEPTH = ier_pkg::DEF_LOG_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ier_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ier_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [ier_pkg::TEMP_W-1:0] temperature,
	input  logic [ier_pkg::ICE_W-1:0] ice_ratio,
	input  logic [ier_pkg::PRES_W-1:0] pressure,
	input  logic signed [ier_pkg::VAP_W-1:0] vapor_ratio,
	output logic out_valid,
	input  logic out_stall,
	output logic [ier_pkg::RAD_W-1:0] radius
);
	import ier_pkg::*;

	localparam int unsigned NST = 7;

	logic [16:0] freeze_q, gas_q;
	logic [15:0] vfac_q;
	logic [19:0] min_ice_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freeze_q <= RST_FREEZE;
			gas_q <= RST_GAS;
			vfac_q <= RST_VFAC;
			min_ice_q <= RST_MIN_ICE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREEZE: freeze_q <= cfg_data[16:0];
				REG_GAS: gas_q <= cfg_data[16:0];
				REG_VFAC: vfac_q <= cfg_data[15:0];
				REG_MIN_ICE: min_ice_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipe advances unless the output is held.
	logic adv;
	logic [NST-1:0] v_q;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NST-2:0], in_valid};
	end

	// Stage 1: operand conditioning, band and flags.
	logic [47:0] vq;
	logic [48:0] vden;
	logic signed [17:0] tem2;
	logic [1:0] band;
	assign vq = 48'(vfac_q) * 48'(vapor_ratio[31] ? 32'd0 : vapor_ratio);
	assign vden = (49'd1 << 48) + 49'(vq);
	assign tem2 = $signed({1'b0, temperature}) - $signed({1'b0, freeze_q});
	always_comb begin
		priority if (tem2 < -18'sd12800) band = 2'd0;
		else if (tem2 < -18'sd10240) band = 2'd1;
		else if (tem2 < -18'sd7680) band = 2'd2;
		else band = 2'd3;
	end

	logic [ICE_W-1:0] qi_s1;
	logic [PRES_W-1:0] p_s1;
	logic [16:0] t_s1, r_s1;
	logic [48:0] vd_s1;
	logic [1:0] band_s1;
	ier_flags_t fl_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			qi_s1 <= ice_ratio;
			p_s1 <= pressure;
			t_s1 <= temperature == '0 ? 17'd1 : temperature;
			r_s1 <= gas_q == '0 ? 17'd1 : gas_q;
			vd_s1 <= vden;
			band_s1 <= band;
			fl_s1.below <= ice_ratio < ICE_W'(min_ice_q);
			fl_s1.floor_only <= ice_ratio == '0 || pressure == '0;
		end
	end

	// Stages 2 and 3: five logarithms in parallel.
	logic [LOG_W-1:0] l_qi, l_p, l_t, l_r, l_v;
	ier_log2 #(.IN_W(ICE_W), .DEPTH(LOG_TABLE_DEPTH)) u_lqi (.clk, .en1(adv), .en2(adv),
		.x(qi_s1 == '0 ? ICE_W'(1) : qi_s1), .lg(l_qi));
	ier_log2 #(.IN_W(PRES_W), .DEPTH(LOG_TABLE_DEPTH)) u_lp (.clk, .en1(adv), .en2(adv),
		.x(p_s1 == '0 ? PRES_W'(1) : p_s1), .lg(l_p));
	ier_log2 #(.IN_W(17), .DEPTH(LOG_TABLE_DEPTH)) u_lt (.clk, .en1(adv), .en2(adv),
		.x(t_s1), .lg(l_t));
	ier_log2 #(.IN_W(17), .DEPTH(LOG_TABLE_DEPTH)) u_lr (.clk, .en1(adv), .en2(adv),
		.x(r_s1), .lg(l_r));
	ier_log2 #(.IN_W(49), .DEPTH(LOG_TABLE_DEPTH)) u_lv (.clk, .en1(adv), .en2(adv),
		.x(vd_s1), .lg(l_v));

	logic [1:0] band_s2, band_s3;
	ier_flags_t fl_s2, fl_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			band_s2 <= band_s1;
			band_s3 <= band_s2;
			fl_s2 <= fl_s1;
			fl_s3 <= fl_s2;
		end
	end

	// Stage 4: sum of logs, water content in log domain.
	logic signed [LOG_W+1:0] lw_s4;
	logic [1:0] band_s4;
	ier_flags_t fl_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			lw_s4 <= $signed((LOG_W+2)'(l_qi)) + $signed((LOG_W+2)'(l_p))
				- $signed((LOG_W+2)'(l_r)) - $signed((LOG_W+2)'(l_t))
				- $signed((LOG_W+2)'(l_v)) + $signed((LOG_W+2)'(20 * 65536));
			band_s4 <= band_s3;
			fl_s4 <= fl_s3;
		end
	end

	// Stage 5: exponent times log, floored, plus coefficient.
	logic signed [LOG_W+15:0] bl;
	assign bl = $signed((LOG_W+16)'(lw_s4)) * $signed({1'b0, band_expo(band_s4)});
	logic signed [LOG_W+1:0] lr_s5;
	ier_flags_t fl_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			lr_s5 <= $signed((LOG_W+2)'(bl >>> 16)) + $signed((LOG_W+2)'(band_lcoef(band_s4)))
				+ $signed((LOG_W+2)'(8 * 65536));
			fl_s5 <= fl_s4;
		end
	end

	// Stages 6 and 7: exponential.
	logic [RAD_W-1:0] rad_e;
	ier_flags_t fl_s6, fl_s7;
	ier_exp2 #(.DEPTH(LOG_TABLE_DEPTH)) u_exp (.clk, .en1(adv), .en2(adv), .x(lr_s5),
		.rad(rad_e));
	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s6 <= fl_s5;
			fl_s7 <= fl_s6;
		end
	end

	// Output selection for the special cases.
	always_comb begin
		priority if (fl_s7.below) radius = '0;
		else if (fl_s7.floor_only) radius = RAD_FLOOR;
		else radius = rad_e;
	end
endmodule
